FILE: hdl/chf_pkg.sv
// shared command and status types for the chained hash table
`timescale 1ns / 1ps
package chf_pkg;

	typedef struct packed {
		logic latch;
		logic head_rd;
		logic ent_rd_head;
		logic ent_rd_link;
		logic ins_data;
		logic ins_link;
		logic load_out;
		logic out_found;
		logic out_inserted;
		logic cfg_write;
		logic clr_step;
	} dp_cmd_t;

	typedef struct packed {
		logic head_zero;
		logic key_match;
		logic link_zero;
		logic can_insert;
		logic out_free;
		logic clr_done;
	} dp_sts_t;

endpackage

FILE: hdl/chf_dp.sv
// datapath: bucket head memory, entry memories, item and result registers
`timescale 1ns / 1ps
module chf_dp import chf_pkg::*; #(
	parameter int MAX_LOG2_SIZE = 12,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd_i,
	output dp_sts_t     sts_o,
	input  logic [3:0]  cfg_data,
	input  logic        cmd,
	input  logic [31:0] key,
	input  logic [31:0] start_value,
	input  logic [31:0] trail_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] found_start,
	output logic [31:0] found_length,
	output logic        inserted
);

	localparam int AW = MAX_LOG2_SIZE;
	localparam int PW = MAX_LOG2_SIZE + 1;
	localparam int DEPTH = 1 << MAX_LOG2_SIZE;
	localparam logic [31:0] KMASK = (KEY_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << KEY_BITS) - 32'd1);

	logic [PW-1:0] head_mem [DEPTH];
	logic [95:0]   ent_mem  [DEPTH];
	logic [PW-1:0] link_mem [DEPTH];

	logic          cmd_q;
	logic [31:0]   key_q;
	logic [31:0]   sv_q;
	logic [31:0]   tl_q;
	logic [AW-1:0] bkt_q;
	logic [PW-1:0] head_rd_q;
	logic [95:0]   ent_rd_q;
	logic [PW-1:0] link_rd_q;
	logic [PW-1:0] last_q;
	logic [PW-1:0] count_q;
	logic [PW-1:0] size_q;
	logic [AW-1:0] mask_q;
	logic [AW-1:0] clr_q;

	logic [31:0]   key_m;
	logic [AW-1:0] bkt_in;
	logic [PW-1:0] eff_lg;
	logic [PW-1:0] new_size;
	logic [PW-1:0] ent_ptr;
	logic [AW-1:0] ent_addr;
	logic [PW-1:0] count_p1;

	assign key_m    = key & KMASK;
	assign bkt_in   = key_m[AW-1:0] & mask_q;
	assign count_p1 = count_q + PW'(1);

	always_comb begin
		if (cfg_data == 4'd0) begin
			eff_lg = PW'(1);
		end else if (int'(cfg_data) > MAX_LOG2_SIZE) begin
			eff_lg = PW'(MAX_LOG2_SIZE);
		end else begin
			eff_lg = PW'(cfg_data);
		end
		new_size = PW'(1) << eff_lg;
		ent_ptr  = cmd_i.ent_rd_head ? head_rd_q : link_rd_q;
		ent_addr = AW'(ent_ptr - PW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			size_q    <= PW'(1) << MAX_LOG2_SIZE;
			mask_q    <= '1;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd_i.cfg_write) begin
				count_q <= '0;
				size_q  <= new_size;
				mask_q  <= AW'(new_size - PW'(1));
				clr_q   <= '0;
			end else begin
				if (cmd_i.clr_step) begin
					clr_q <= clr_q + AW'(1);
				end
				if (cmd_i.ins_link) begin
					count_q <= count_p1;
				end
			end
			if (cmd_i.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.latch) begin
			cmd_q <= cmd;
			key_q <= key_m;
			sv_q  <= start_value;
			tl_q  <= trail_length;
			bkt_q <= bkt_in;
		end
		if (cmd_i.head_rd) begin
			head_rd_q <= head_mem[bkt_in];
		end
		if (cmd_i.clr_step) begin
			head_mem[clr_q] <= '0;
		end else if (cmd_i.ins_link && last_q == '0) begin
			head_mem[bkt_q] <= count_p1;
		end
		// last_q holds the last entry read, or zero for an empty bucket
		if (cmd_i.ent_rd_head || cmd_i.ent_rd_link) begin
			ent_rd_q  <= ent_mem[ent_addr];
			link_rd_q <= link_mem[ent_addr];
			last_q    <= ent_ptr;
		end else if (cmd_i.head_rd) begin
			last_q <= '0;
		end
		if (cmd_i.ins_data) begin
			ent_mem[count_q[AW-1:0]]  <= {key_q, sv_q, tl_q};
			link_mem[count_q[AW-1:0]] <= '0;
		end else if (cmd_i.ins_link && last_q != '0) begin
			link_mem[AW'(last_q - PW'(1))] <= count_p1;
		end
		if (cmd_i.load_out) begin
			found        <= cmd_i.out_found;
			inserted     <= cmd_i.out_inserted;
			found_start  <= cmd_i.out_found ? ent_rd_q[63:32] : 32'd0;
			found_length <= cmd_i.out_found ? ent_rd_q[31:0] : 32'd0;
		end
	end

	always_comb begin
		sts_o.head_zero  = (head_rd_q == '0);
		sts_o.key_match  = (ent_rd_q[95:64] == key_q);
		sts_o.link_zero  = (link_rd_q == '0);
		sts_o.can_insert = cmd_q && (count_q < size_q);
		sts_o.out_free   = !out_valid || out_ready;
		sts_o.clr_done   = (clr_q == '1);
	end

endmodule

FILE: hdl/chf_ctrl.sv
// controller: request sequencing, chain walk and table clearing
`timescale 1ns / 1ps
module chf_ctrl import chf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  dp_sts_t sts_i,
	output dp_cmd_t cmd_o
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_CMP, S_MISS, S_LINK, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   found_q, found_d;
	logic   ins_q, ins_d;

	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	always_comb begin
		cmd_o   = '0;
		state_d = state_q;
		found_d = found_q;
		ins_d   = ins_q;
		case (state_q)
			S_CLEAR: begin
				cmd_o.clr_step = 1'b1;
				if (sts_i.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd_o.latch   = 1'b1;
					cmd_o.head_rd = 1'b1;
					state_d       = S_HEAD;
				end
			end
			S_HEAD: begin
				if (sts_i.head_zero) begin
					state_d = S_MISS;
				end else begin
					cmd_o.ent_rd_head = 1'b1;
					state_d           = S_CMP;
				end
			end
			S_CMP: begin
				if (sts_i.key_match) begin
					found_d = 1'b1;
					ins_d   = 1'b0;
					state_d = S_DONE;
				end else if (sts_i.link_zero) begin
					state_d = S_MISS;
				end else begin
					cmd_o.ent_rd_link = 1'b1;
				end
			end
			S_MISS: begin
				found_d = 1'b0;
				if (sts_i.can_insert) begin
					cmd_o.ins_data = 1'b1;
					state_d        = S_LINK;
				end else begin
					ins_d   = 1'b0;
					state_d = S_DONE;
				end
			end
			S_LINK: begin
				cmd_o.ins_link = 1'b1;
				ins_d          = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (sts_i.out_free) begin
					cmd_o.load_out     = 1'b1;
					cmd_o.out_found    = found_q;
					cmd_o.out_inserted = ins_q;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_valid && cfg_ready) begin
			cmd_o.cfg_write = 1'b1;
			cmd_o.clr_step  = 1'b0;
			state_d         = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			found_q <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			ins_q   <= ins_d;
		end
	end

endmodule

FILE: hdl/chained_hash_find_insert.sv
// top level of the chained hash table with find and insert
// a request passes S_HEAD, one S_CMP per entry compared, then S_MISS on a miss and S_LINK
// when a new entry is linked in, and waits in S_DONE while a held result waits for out_ready
// throughput: one request at a time; the next is taken the cycle after the result is loaded
// reset and every log2_table_size write start a clearing pass over all 2**MAX_LOG2_SIZE
// bucket heads, during which no request is taken
`timescale 1ns / 1ps
module chained_hash_find_insert import chf_pkg::*; #(
	parameter int MAX_LOG2_SIZE = 12,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  log2_table_size,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] key,
	input  logic [31:0] start_value,
	input  logic [31:0] trail_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] found_start,
	output logic [31:0] found_length,
	output logic        inserted
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	chf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts_i     (dp_sts),
		.cmd_o     (dp_cmd)
	);

	chf_dp #(
		.MAX_LOG2_SIZE (MAX_LOG2_SIZE),
		.KEY_BITS      (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_i        (dp_cmd),
		.sts_o        (dp_sts),
		.cfg_data     (log2_table_size),
		.cmd          (cmd),
		.key          (key),
		.start_value  (start_value),
		.trail_length (trail_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.found_start  (found_start),
		.found_length (found_length),
		.inserted     (inserted)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");
	a_clear_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("request taken during clearing pass");
	a_link_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.ins_link |-> $past(dp_cmd.ins_data))
		else $error("link written without entry write");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> dp_sts.out_free)
		else $error("result overwrote a pending transfer");
`endif

endmodule
